// ===== hw/rtl/polyline_miter_offset_top_macros.svh =====
// Assertion helpers shared by the RTL files. They expect clk and arst_n in scope.
`ifndef POLYLINE_MITER_OFFSET_TOP_MACROS_SVH
`define POLYLINE_MITER_OFFSET_TOP_MACROS_SVH

// Same-cycle implication.
`define PMO_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PMO_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pmo_pkg.sv =====
package pmo_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic MODE_SQRT = 1'b0;
	localparam logic MODE_DIV  = 1'b1;

	localparam logic [4:0] SQRT_STEPS  = 5'd31;
	localparam logic [4:0] UNIT_QBITS  = 5'd15;
	localparam logic [4:0] MITER_QBITS = 5'd17;

	// 2^40 / c with 17 quotient bits starts from 2^40 >> 17.
	localparam logic [30:0] MITER_REM0 = 31'd8388608;
	localparam logic [15:0] MITER_MAX  = 16'hFFFF;

	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] hx;
		logic signed [15:0] hy;
		logic               has_held;
		logic               last;
	} job_t;

	typedef struct packed {
		logic        mode;
		logic [61:0] radicand;
		logic [30:0] rem0;
		logic [30:0] divisor;
		logic [4:0]  count;
	} iter_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_stat_t;

endpackage

// ===== hw/rtl/polyline_miter_offset_top.sv =====
// Channel  Direction  Handshake            Payload
// in       into       in_valid / in_stall  point_x, point_y, ring_end
// out      out of     out_valid/ out_stall shifted_x, shifted_y, ring_last
// cfg      into       cfg_wr_en            cfg_wr_data (offset_distance)
//
// A vertex that follows another in its ring runs through the back end as a 31-step root
// and two 15-step divisions for each of the segment normal and the miter direction, a
// 17-step division for the miter factor, then multiply, add and round for each axis. A ring
// end after a held vertex also runs the ring's final vertex; an opening vertex is only held.
// Reset is asynchronous and clears the held vertex, the incoming normal and the queue.
// Input stalls only while the two-entry queue is full; a stalled result waits in its register.
module polyline_miter_offset_top #(
	parameter int QDEPTH = pmo_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic               ring_end,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] shifted_x,
	output logic signed [15:0] shifted_y,
	output logic               ring_last,
	input  logic               cfg_wr_en,
	input  logic signed [19:0] cfg_wr_data
);
	import pmo_pkg::*;

	logic signed [19:0] offset_q;
	logic               push;
	job_t               push_job;
	logic               pop;
	job_t               pop_job;
	logic               q_full;
	logic               q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_wr_en) begin
			offset_q <= cfg_wr_data;
		end
	end

	pmo_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.point_x  (point_x),
		.point_y  (point_y),
		.ring_end (ring_end),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	pmo_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.pop_job   (pop_job),
		.full      (q_full),
		.not_empty (q_valid)
	);

	pmo_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_job     (pop_job),
		.pop       (pop),
		.offset    (offset_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.shifted_x (shifted_x),
		.shifted_y (shifted_y),
		.ring_last (ring_last)
	);

endmodule

// ===== hw/rtl/pmo_front.sv =====
module pmo_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic               ring_end,
	input  logic               q_full,
	output logic               push,
	output pmo_pkg::job_t      push_job
);
	import pmo_pkg::*;

	logic signed [15:0] held_x_q;
	logic signed [15:0] held_y_q;
	logic               have_held_q;

	assign in_stall = q_full;
	assign push     = in_valid & ~q_full;

	always_comb begin
		push_job.px       = point_x;
		push_job.py       = point_y;
		push_job.hx       = held_x_q;
		push_job.hy       = held_y_q;
		push_job.has_held = have_held_q;
		push_job.last     = ring_end;
	end

	// The vertex is held until its outgoing segment is known; a ring end drops it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q    <= '0;
			held_y_q    <= '0;
			have_held_q <= 1'b0;
		end else if (push) begin
			if (ring_end) begin
				held_x_q    <= '0;
				held_y_q    <= '0;
				have_held_q <= 1'b0;
			end else begin
				held_x_q    <= point_x;
				held_y_q    <= point_y;
				have_held_q <= 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/pmo_queue.sv =====
`include "polyline_miter_offset_top_macros.svh"

module pmo_queue #(
	parameter int DEPTH = pmo_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pmo_pkg::job_t push_job,
	input  logic          pop,
	output pmo_pkg::job_t pop_job,
	output logic          full,
	output logic          not_empty
);
	import pmo_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign pop_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PMO_ASSERT_IMP(a_no_overflow, push, !full, "item pushed into a full queue")
	`PMO_ASSERT_IMP(a_no_underflow, pop, not_empty, "item popped from an empty queue")
	`PMO_ASSERT_NXT(a_count_up, push && !pop, count_q == CW'($past(count_q) + 1'b1), "count lost")

endmodule

// ===== hw/rtl/pmo_iter.sv =====
module pmo_iter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  pmo_pkg::iter_req_t req,
	output pmo_pkg::iter_stat_t stat,
	output logic [30:0]        result
);
	import pmo_pkg::*;

	logic        mode_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [61:0] rad_q;
	logic [34:0] rem_q;
	logic [30:0] res_q;
	logic [30:0] div_q;

	logic [34:0] trial;
	logic [34:0] cmp;
	logic        ge;

	// Square root brings in two radicand bits a step; division brings in a zero.
	always_comb begin
		if (mode_q == MODE_SQRT) begin
			trial = {rem_q[32:0], rad_q[61:60]};
			cmp   = {2'b00, res_q, 2'b01};
		end else begin
			trial = {rem_q[33:0], 1'b0};
			cmp   = {4'b0000, div_q};
		end
		ge = (trial >= cmp);
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= req.mode;
			rad_q  <= req.radicand;
			div_q  <= req.divisor;
			res_q  <= '0;
			rem_q  <= (req.mode == MODE_SQRT) ? 35'd0 : {4'b0000, req.rem0};
		end else if (busy_q) begin
			rad_q <= {rad_q[59:0], 2'b00};
			rem_q <= ge ? trial - cmp : trial;
			res_q <= {res_q[29:0], ge};
		end
	end

endmodule

// ===== hw/rtl/pmo_back.sv =====
`include "polyline_miter_offset_top_macros.svh"

module pmo_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  pmo_pkg::job_t      q_job,
	output logic               pop,
	input  logic signed [19:0] offset,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] shifted_x,
	output logic signed [15:0] shifted_y,
	output logic               ring_last
);
	import pmo_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_SQX  = 5'd1;
	localparam logic [4:0] S_SQY  = 5'd2;
	localparam logic [4:0] S_SQZ  = 5'd3;
	localparam logic [4:0] S_SQW  = 5'd4;
	localparam logic [4:0] S_DXW  = 5'd5;
	localparam logic [4:0] S_DYW  = 5'd6;
	localparam logic [4:0] S_SEGN = 5'd7;
	localparam logic [4:0] S_ESET = 5'd8;
	localparam logic [4:0] S_C1   = 5'd9;
	localparam logic [4:0] S_C2   = 5'd10;
	localparam logic [4:0] S_K    = 5'd11;
	localparam logic [4:0] S_KW   = 5'd12;
	localparam logic [4:0] S_M1   = 5'd13;
	localparam logic [4:0] S_M2   = 5'd14;
	localparam logic [4:0] S_ADD  = 5'd15;
	localparam logic [4:0] S_RND  = 5'd16;
	localparam logic [4:0] S_OUT  = 5'd17;

	localparam logic PH_SEG  = 1'b0;
	localparam logic PH_EMIT = 1'b1;

	logic [4:0]         state_q;
	logic               phase_q;
	logic               axis_q;
	job_t               job_q;
	logic signed [16:0] vx_q, vy_q;
	logic [33:0]        acc_q;
	logic [30:0]        len_q;
	logic signed [15:0] ux_q, uy_q;
	logic signed [15:0] nx_q, ny_q;
	logic signed [15:0] inx_q, iny_q;
	logic signed [15:0] epx_q, epy_q;
	logic signed [15:0] ax_q, ay_q, bx_q, by_q;
	logic               elast_q;
	logic signed [31:0] c_q;
	logic [15:0]        k_q;
	logic signed [32:0] p1_q;
	logic signed [52:0] t_q;
	logic signed [52:0] sum_q;
	logic signed [15:0] rx_q;
	logic signed [15:0] ry_q;

	logic               out_valid_q;
	logic signed [15:0] shifted_x_q, shifted_y_q;
	logic               ring_last_q;

	logic                start;
	iter_req_t           req;
	iter_stat_t          istat;
	logic [30:0]         ires;

	pmo_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.stat   (istat),
		.result (ires)
	);

	// Datapath helpers.
	logic signed [16:0] sq_op;
	logic signed [33:0] sq_w;
	logic [16:0]        absx, absy;
	logic signed [15:0] qmag;
	logic signed [15:0] nsx, nsy;
	logic signed [15:0] cm_a, cm_b;
	logic signed [31:0] cp_w;
	logic signed [15:0] e_sel;
	logic signed [16:0] k_s;
	logic signed [32:0] p1_w;
	logic signed [52:0] t_w;
	logic signed [15:0] p_sel;
	logic signed [52:0] sum_w;
	logic signed [22:0] qt;
	logic               bump;
	logic signed [22:0] qr;
	logic signed [15:0] sat_w;
	logic               out_free;
	logic               iter_wait;

	assign sq_op = (state_q == S_SQX) ? vx_q : vy_q;
	assign sq_w  = sq_op * sq_op;
	assign absx  = vx_q[16] ? $unsigned(-vx_q) : $unsigned(vx_q);
	assign absy  = vy_q[16] ? $unsigned(-vy_q) : $unsigned(vy_q);
	assign qmag  = $signed({1'b0, ires[14:0]});

	// The cosine is taken against the outgoing normal unless it is missing.
	assign nsx  = (bx_q != '0 || by_q != '0) ? bx_q : ax_q;
	assign nsy  = (bx_q != '0 || by_q != '0) ? by_q : ay_q;
	assign cm_a = (state_q == S_C1) ? ux_q : uy_q;
	assign cm_b = (state_q == S_C1) ? nsx : nsy;
	assign cp_w = cm_a * cm_b;

	assign e_sel = axis_q ? uy_q : ux_q;
	assign k_s   = $signed({1'b0, k_q});
	assign p1_w  = e_sel * k_s;
	assign t_w   = p1_q * offset;
	assign p_sel = axis_q ? epy_q : epx_q;
	assign sum_w = $signed({{7{p_sel[15]}}, p_sel, 30'b0}) + t_q;

	// Shift by 2^30 truncating toward zero, then clamp to 16 bits.
	assign qt   = sum_q[52:30];
	assign bump = sum_q[52] && (sum_q[29:0] != '0);
	assign qr   = qt + $signed({22'b0, bump});
	always_comb begin
		if (qr > 23'sd32767) begin
			sat_w = 16'sh7FFF;
		end else if (qr < -23'sd32768) begin
			sat_w = -16'sh8000;
		end else begin
			sat_w = qr[15:0];
		end
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = (state_q == S_IDLE) && q_valid;
	assign iter_wait = (state_q == S_SQW) || (state_q == S_DXW) || (state_q == S_DYW) ||
		(state_q == S_KW);

	always_comb begin
		start       = 1'b0;
		req         = '0;
		req.divisor = len_q;
		case (state_q)
			S_SQZ: begin
				start        = (acc_q != '0);
				req.mode     = MODE_SQRT;
				req.radicand = {acc_q, 28'b0};
				req.count    = SQRT_STEPS;
			end
			S_SQW: begin
				start     = istat.done;
				req.mode  = MODE_DIV;
				req.rem0  = {1'b0, absx, 13'b0};
				req.divisor = ires;
				req.count = UNIT_QBITS;
			end
			S_DXW: begin
				start     = istat.done;
				req.mode  = MODE_DIV;
				req.rem0  = {1'b0, absy, 13'b0};
				req.count = UNIT_QBITS;
			end
			S_K: begin
				start       = (c_q > $signed({1'b0, MITER_REM0}));
				req.mode    = MODE_DIV;
				req.rem0    = MITER_REM0;
				req.divisor = c_q[30:0];
				req.count   = MITER_QBITS;
			end
			default: begin
				start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			inx_q       <= '0;
			iny_q       <= '0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (q_job.has_held) begin
							state_q <= S_SQX;
						end else if (q_job.last) begin
							inx_q   <= '0;
							iny_q   <= '0;
							state_q <= S_ESET;
						end else begin
							inx_q <= '0;
							iny_q <= '0;
						end
					end
				end
				S_SQX:  state_q <= S_SQY;
				S_SQY:  state_q <= S_SQZ;
				S_SQZ: begin
					if (acc_q != '0) begin
						state_q <= S_SQW;
					end else begin
						state_q <= (phase_q == PH_SEG) ? S_SEGN : S_C1;
					end
				end
				S_SQW: if (istat.done) state_q <= S_DXW;
				S_DXW: if (istat.done) state_q <= S_DYW;
				S_DYW: begin
					if (istat.done) begin
						state_q <= (phase_q == PH_SEG) ? S_SEGN : S_C1;
					end
				end
				S_SEGN: state_q <= S_ESET;
				S_ESET: state_q <= S_SQX;
				S_C1:   state_q <= S_C2;
				S_C2:   state_q <= S_K;
				S_K: begin
					state_q <= start ? S_KW : S_M1;
				end
				S_KW:  if (istat.done) state_q <= S_M1;
				S_M1:  state_q <= S_M2;
				S_M2:  state_q <= S_ADD;
				S_ADD: state_q <= S_RND;
				S_RND: state_q <= axis_q ? S_OUT : S_M1;
				S_OUT: begin
					if (out_free) begin
						if (elast_q) begin
							state_q <= S_IDLE;
						end else if (job_q.last) begin
							inx_q   <= '0;
							iny_q   <= '0;
							state_q <= S_ESET;
						end else begin
							inx_q   <= nx_q;
							iny_q   <= ny_q;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					job_q   <= q_job;
					vx_q    <= 17'(q_job.px) - 17'(q_job.hx);
					vy_q    <= 17'(q_job.py) - 17'(q_job.hy);
					phase_q <= PH_SEG;
					nx_q    <= '0;
					ny_q    <= '0;
					epx_q   <= q_job.px;
					epy_q   <= q_job.py;
					ax_q    <= '0;
					ay_q    <= '0;
					bx_q    <= '0;
					by_q    <= '0;
					elast_q <= 1'b1;
				end
			end
			S_SQX: acc_q <= sq_w[33:0];
			S_SQY: acc_q <= acc_q + sq_w[33:0];
			S_SQZ: begin
				if (acc_q == '0) begin
					ux_q <= '0;
					uy_q <= '0;
				end
			end
			S_SQW: if (istat.done) len_q <= ires;
			S_DXW: if (istat.done) ux_q <= vx_q[16] ? -qmag : qmag;
			S_DYW: if (istat.done) uy_q <= vy_q[16] ? -qmag : qmag;
			S_SEGN: begin
				// Segment normal is (-dy, dx); the held vertex joins the incoming one.
				nx_q    <= -uy_q;
				ny_q    <= ux_q;
				bx_q    <= -uy_q;
				by_q    <= ux_q;
				ax_q    <= inx_q;
				ay_q    <= iny_q;
				epx_q   <= job_q.hx;
				epy_q   <= job_q.hy;
				elast_q <= 1'b0;
			end
			S_ESET: begin
				vx_q    <= 17'(ax_q) + 17'(bx_q);
				vy_q    <= 17'(ay_q) + 17'(by_q);
				phase_q <= PH_EMIT;
			end
			S_C1: c_q <= cp_w;
			S_C2: c_q <= c_q + cp_w;
			S_K: begin
				k_q    <= MITER_MAX;
				axis_q <= 1'b0;
			end
			S_KW: if (istat.done) k_q <= ires[16] ? MITER_MAX : ires[15:0];
			S_M1:  p1_q  <= p1_w;
			S_M2:  t_q   <= t_w;
			S_ADD: sum_q <= sum_w;
			S_RND: begin
				if (!axis_q) begin
					rx_q   <= sat_w;
					axis_q <= 1'b1;
				end else begin
					ry_q <= sat_w;
				end
			end
			S_OUT: begin
				if (out_free) begin
					shifted_x_q <= rx_q;
					shifted_y_q <= ry_q;
					ring_last_q <= elast_q;
					if (!elast_q && job_q.last) begin
						// The ring's final vertex follows, joined only by the segment before it.
						epx_q   <= job_q.px;
						epy_q   <= job_q.py;
						ax_q    <= nx_q;
						ay_q    <= ny_q;
						bx_q    <= '0;
						by_q    <= '0;
						elast_q <= 1'b1;
					end
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign shifted_x = shifted_x_q;
	assign shifted_y = shifted_y_q;
	assign ring_last = ring_last_q;

	`PMO_ASSERT_IMP(a_done_in_wait, istat.done, iter_wait, "iterative result outside a wait state")
	`PMO_ASSERT_IMP(a_pop_idle, pop, state_q == S_IDLE, "item popped while busy")
	`PMO_ASSERT_IMP(a_idle_free, state_q == S_IDLE, !istat.busy, "shared unit busy while idle")

endmodule
